[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert macros
// shared concurrent assertion shorthands, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/dsp_pkg.sv]
// ----------------------------------------------------------------------------
// dsp_pkg
// shared widths and register codes of the dag shortest path block
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int VTX_W      = 6;   // vertex index field
  localparam int CNT_W      = 7;   // counts up to 64
  localparam int IN_W_W     = 16;  // edge weight field
  localparam int DIST_W     = 32;  // distance field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT  = 2'd0,
    REG_SOURCE_VERTEX = 2'd1
  } cfg_reg_t;

endpackage

[hw/rtl/dsp_ifs.sv]
// ----------------------------------------------------------------------------
// dsp channel interfaces
// edge input, vertex result and register write channels
// ----------------------------------------------------------------------------
interface dsp_edge_if;
  logic                               valid;
  logic                               ready;
  logic                               edge_present;
  logic        [dsp_pkg::VTX_W-1:0]   edge_from;
  logic        [dsp_pkg::VTX_W-1:0]   edge_to;
  logic signed [dsp_pkg::IN_W_W-1:0]  edge_weight;
  logic                               last_edge;

  modport source (output valid, edge_present, edge_from, edge_to, edge_weight, last_edge,
                  input ready);
  modport sink   (input valid, edge_present, edge_from, edge_to, edge_weight, last_edge,
                  output ready);
endinterface

interface dsp_result_if;
  logic                               valid;
  logic                               ready;
  logic        [dsp_pkg::VTX_W-1:0]   vertex_index;
  logic                               reachable;
  logic signed [dsp_pkg::DIST_W-1:0]  distance;
  logic                               has_predecessor;
  logic        [dsp_pkg::VTX_W-1:0]   predecessor;
  logic                               last_vertex;

  modport source (output valid, vertex_index, reachable, distance, has_predecessor,
                  predecessor, last_vertex, input ready);
  modport sink   (input valid, vertex_index, reachable, distance, has_predecessor,
                  predecessor, last_vertex, output ready);
endinterface

interface dsp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dsp_pkg::CFG_IDX_W-1:0]       index;
  logic [dsp_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dag_single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// dag_single_source_shortest_paths
// loads weighted edges into adjacency lists, then orders the vertices by
// depth-first search and relaxes edges in topological order
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  in_ch   | in  | one edge (or bare end marker), last_edge starts the walk
//  out_ch  | out | one result per vertex, ascending, last_vertex on the final
//  cfg_ch  | in  | register write: vertex_count, source_vertex
//
//  edge beats are taken one per cycle; the degree read-modify-write is
//  forwarded across back-to-back beats on the same tail vertex
//  the walk after the last beat runs the search, relaxation and results,
//  all bound by the single read port of each memory
//  in_ch is held off from the last beat until the final result is taken
//  reset is synchronous; adjacency, stack, order and distance memories
//  need no clearing, degree and visit state use per-vertex valid bits
// ----------------------------------------------------------------------------
module dag_single_source_shortest_paths #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  dsp_edge_if.sink      in_ch,
  dsp_result_if.source  out_ch,
  dsp_cfg_if.sink       cfg_ch
);

  localparam int VW     = dsp_pkg::VTX_W;
  localparam int CW     = dsp_pkg::CNT_W;
  localparam int DW     = dsp_pkg::DIST_W;
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int ADJ_D  = 1 << (2 * IDX_W);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  // walk sequencer
  typedef enum logic [15:0] {
    S_LOAD  = 16'h0001,
    S_ROOT  = 16'h0002,
    S_DEG   = 16'h0004,
    S_EDGE  = 16'h0008,
    S_ADJ   = 16'h0010,
    S_POP   = 16'h0020,
    S_INIT  = 16'h0040,
    S_RV    = 16'h0080,
    S_RU    = 16'h0100,
    S_RD    = 16'h0200,
    S_RE    = 16'h0400,
    S_RA    = 16'h0800,
    S_RC    = 16'h1000,
    S_OREQ  = 16'h2000,
    S_OLD   = 16'h4000,
    S_OWAIT = 16'h8000
  } state_t;

  // memories
  logic [VW+WEIGHT_BITS-1:0] adj_mem  [ADJ_D];
  logic [CW-1:0]             deg_mem  [MAX_VERTICES];
  logic [VW+CW-1:0]          stk_mem  [MAX_VERTICES];
  logic [VW-1:0]             topo_mem [MAX_VERTICES];
  logic [DW+VW-1:0]          dist_mem [MAX_VERTICES];

  logic [VW+WEIGHT_BITS-1:0] adj_q;
  logic [CW-1:0]             deg_q;
  logic                      deg_hit_q;
  logic [VW+CW-1:0]          stk_q;
  logic [VW-1:0]             topo_q;
  logic [DW+VW-1:0]          dist_q;

  // memory access controls
  logic                      adj_we;
  logic [2*IDX_W-1:0]        adj_waddr, adj_raddr;
  logic [VW+WEIGHT_BITS-1:0] adj_wdata;
  logic                      deg_we;
  logic [IDX_W-1:0]          deg_waddr, deg_raddr;
  logic [CW-1:0]             deg_wdata;
  logic                      stk_we;
  logic [IDX_W-1:0]          stk_addr;
  logic                      topo_we;
  logic [IDX_W-1:0]          topo_waddr, topo_raddr;
  logic                      dist_we;
  logic [IDX_W-1:0]          dist_waddr, dist_raddr;
  logic [DW+VW-1:0]          dist_wdata;

  // control registers
  state_t                 st_r, st_nxt;
  logic [CW-1:0]          vcount_r;
  logic [VW-1:0]          src_r;
  logic                   s1_v_r;
  logic                   fwd_v_r, fwd_v_nxt;
  logic [VW-1:0]          fwd_idx_r;
  logic [CW-1:0]          fwd_val_r;
  logic [MAX_VERTICES-1:0] deg_vld_r, deg_vld_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] dist_vld_r, dist_vld_nxt;
  logic [MAX_VERTICES-1:0] pred_vld_r, pred_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // load stage payload
  logic                   s1_pres_r, s1_last_r;
  logic [VW-1:0]          s1_from_r, s1_to_r;
  logic [WEIGHT_BITS-1:0] s1_w_r;

  // walk payload
  logic [CW-1:0]          root_r, root_nxt;
  logic [CW-1:0]          sp_r, sp_nxt;
  logic [VW-1:0]          top_u_r, top_u_nxt;
  logic [CW-1:0]          top_i_r, top_i_nxt;
  logic [CW-1:0]          top_deg_r, top_deg_nxt;
  logic [CW-1:0]          done_r, done_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic signed [DW-1:0]   du_r, du_nxt;
  logic [VW-1:0]          v_r, v_nxt;
  logic signed [DW-1:0]   cand_r, cand_nxt;
  logic [CW-1:0]          ov_r, ov_nxt;

  // result register
  logic [VW-1:0]          o_idx_r, o_idx_nxt;
  logic                   o_reach_r, o_reach_nxt;
  logic signed [DW-1:0]   o_dist_r, o_dist_nxt;
  logic                   o_hasp_r, o_hasp_nxt;
  logic [VW-1:0]          o_pred_r, o_pred_nxt;
  logic                   o_last_r, o_last_nxt;

  logic                   in_fire, out_fire, cfg_fire;
  logic [CW-1:0]          n_w;
  logic [CW-1:0]          deg_cur;
  logic                   load_ok;
  logic [VW-1:0]          adj_tgt;
  logic signed [DW-1:0]   adj_wext;
  logic signed [DW-1:0]   sum_w;
  logic [VW-1:0]          stk_u;
  logic [CW-1:0]          stk_i;
  logic                   better;

  // active vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount_r == '0) begin
      n_w = CW'(1);
    end else if (vcount_r > MAX_CNT) begin
      n_w = MAX_CNT;
    end else begin
      n_w = vcount_r;
    end
  end

  assign in_ch.ready  = (st_r == S_LOAD) && !(s1_v_r && s1_last_r);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.vertex_index    = o_idx_r;
  assign out_ch.reachable       = o_reach_r;
  assign out_ch.distance        = o_dist_r;
  assign out_ch.has_predecessor = o_hasp_r;
  assign out_ch.predecessor     = o_pred_r;
  assign out_ch.last_vertex     = o_last_r;

  // degree of the tail in the load stage, forwarded from the write one beat back
  assign deg_cur = (fwd_v_r && fwd_idx_r == s1_from_r) ? fwd_val_r
                 : (deg_hit_q ? deg_q : '0);
  assign load_ok = s1_v_r && s1_pres_r && (CW'(s1_from_r) < n_w) && (CW'(s1_to_r) < n_w)
                 && (deg_cur < MAX_CNT);

  assign adj_tgt  = adj_q[VW+WEIGHT_BITS-1:WEIGHT_BITS];
  assign adj_wext = DW'($signed(adj_q[WEIGHT_BITS-1:0]));
  assign stk_u    = stk_q[VW+CW-1:CW];
  assign stk_i    = stk_q[CW-1:0];
  assign better   = !dist_vld_r[v_r[IDX_W-1:0]] || (cand_r < $signed(dist_q[DW+VW-1:VW]));

  dsp_sat_add u_sat_add (
    .dist_i   (du_r),
    .weight_i (adj_wext),
    .sum_o    (sum_w)
  );

  always_comb begin
    st_nxt        = st_r;
    fwd_v_nxt     = fwd_v_r;
    deg_vld_nxt   = deg_vld_r;
    visited_nxt   = visited_r;
    dist_vld_nxt  = dist_vld_r;
    pred_vld_nxt  = pred_vld_r;
    out_valid_nxt = out_valid_r;
    root_nxt      = root_r;
    sp_nxt        = sp_r;
    top_u_nxt     = top_u_r;
    top_i_nxt     = top_i_r;
    top_deg_nxt   = top_deg_r;
    done_nxt      = done_r;
    k_nxt         = k_r;
    du_nxt        = du_r;
    v_nxt         = v_r;
    cand_nxt      = cand_r;
    ov_nxt        = ov_r;
    o_idx_nxt     = o_idx_r;
    o_reach_nxt   = o_reach_r;
    o_dist_nxt    = o_dist_r;
    o_hasp_nxt    = o_hasp_r;
    o_pred_nxt    = o_pred_r;
    o_last_nxt    = o_last_r;

    adj_we     = 1'b0;
    adj_waddr  = {s1_from_r[IDX_W-1:0], deg_cur[IDX_W-1:0]};
    adj_wdata  = {s1_to_r, s1_w_r};
    adj_raddr  = {top_u_r[IDX_W-1:0], top_i_r[IDX_W-1:0]};
    deg_we     = 1'b0;
    deg_waddr  = s1_from_r[IDX_W-1:0];
    deg_wdata  = deg_cur + CW'(1);
    deg_raddr  = in_ch.edge_from[IDX_W-1:0];
    stk_we     = 1'b0;
    stk_addr   = IDX_W'(sp_r - CW'(1));
    topo_we    = 1'b0;
    topo_waddr = done_r[IDX_W-1:0];
    topo_raddr = IDX_W'(k_r - CW'(1));
    dist_we    = 1'b0;
    dist_waddr = v_r[IDX_W-1:0];
    dist_wdata = {cand_r, top_u_r};
    dist_raddr = ov_r[IDX_W-1:0];

    unique case (st_r)
      S_LOAD: begin
        if (load_ok) begin
          adj_we = 1'b1;
          deg_we = 1'b1;
          deg_vld_nxt[s1_from_r[IDX_W-1:0]] = 1'b1;
        end
        // forward only to the very next beat, later beats read the memory
        fwd_v_nxt = load_ok;
        if (s1_v_r && s1_last_r) begin
          root_nxt = '0;
          sp_nxt   = '0;
          done_nxt = '0;
          st_nxt   = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_r == n_w) begin
          st_nxt = S_INIT;
        end else if (visited_r[root_r[IDX_W-1:0]]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          visited_nxt[root_r[IDX_W-1:0]] = 1'b1;
          top_u_nxt = VW'(root_r);
          top_i_nxt = '0;
          sp_nxt    = CW'(1);
          deg_raddr = root_r[IDX_W-1:0];
          st_nxt    = S_DEG;
        end
      end
      S_DEG: begin
        top_deg_nxt = deg_hit_q ? deg_q : '0;
        st_nxt      = S_EDGE;
      end
      S_EDGE: begin
        if (top_i_r < top_deg_r) begin
          top_i_nxt = top_i_r + CW'(1);
          st_nxt    = S_ADJ;
        end else begin
          // vertex finished
          topo_we  = 1'b1;
          done_nxt = done_r + CW'(1);
          sp_nxt   = sp_r - CW'(1);
          if (sp_r == CW'(1)) begin
            root_nxt = root_r + CW'(1);
            st_nxt   = S_ROOT;
          end else begin
            stk_addr = IDX_W'(sp_r - CW'(2));
            st_nxt   = S_POP;
          end
        end
      end
      S_ADJ: begin
        if ((CW'(adj_tgt) < n_w) && !visited_r[adj_tgt[IDX_W-1:0]] && (sp_r < MAX_CNT)) begin
          stk_we = 1'b1;
          visited_nxt[adj_tgt[IDX_W-1:0]] = 1'b1;
          top_u_nxt = adj_tgt;
          top_i_nxt = '0;
          sp_nxt    = sp_r + CW'(1);
          deg_raddr = adj_tgt[IDX_W-1:0];
          st_nxt    = S_DEG;
        end else begin
          st_nxt = S_EDGE;
        end
      end
      S_POP: begin
        top_u_nxt = stk_u;
        top_i_nxt = stk_i;
        deg_raddr = stk_u[IDX_W-1:0];
        st_nxt    = S_DEG;
      end
      S_INIT: begin
        dist_vld_nxt = '0;
        pred_vld_nxt = '0;
        if (CW'(src_r) < n_w) begin
          dist_vld_nxt[src_r[IDX_W-1:0]] = 1'b1;
          dist_we    = 1'b1;
          dist_waddr = src_r[IDX_W-1:0];
          dist_wdata = '0;
        end
        k_nxt  = done_r;
        st_nxt = S_RV;
      end
      S_RV: begin
        if (k_r == '0) begin
          ov_nxt = '0;
          st_nxt = S_OREQ;
        end else begin
          k_nxt  = k_r - CW'(1);
          st_nxt = S_RU;
        end
      end
      S_RU: begin
        top_u_nxt = topo_q;
        if (dist_vld_r[topo_q[IDX_W-1:0]]) begin
          deg_raddr  = topo_q[IDX_W-1:0];
          dist_raddr = topo_q[IDX_W-1:0];
          st_nxt     = S_RD;
        end else begin
          st_nxt = S_RV;
        end
      end
      S_RD: begin
        top_deg_nxt = deg_hit_q ? deg_q : '0;
        du_nxt      = $signed(dist_q[DW+VW-1:VW]);
        top_i_nxt   = '0;
        st_nxt      = S_RE;
      end
      S_RE: begin
        if (top_i_r < top_deg_r) begin
          top_i_nxt = top_i_r + CW'(1);
          st_nxt    = S_RA;
        end else begin
          st_nxt = S_RV;
        end
      end
      S_RA: begin
        if (CW'(adj_tgt) < n_w) begin
          v_nxt      = adj_tgt;
          cand_nxt   = sum_w;
          dist_raddr = adj_tgt[IDX_W-1:0];
          st_nxt     = S_RC;
        end else begin
          st_nxt = S_RE;
        end
      end
      S_RC: begin
        if (better) begin
          dist_we = 1'b1;
          dist_vld_nxt[v_r[IDX_W-1:0]] = 1'b1;
          pred_vld_nxt[v_r[IDX_W-1:0]] = 1'b1;
          // a self-loop lowers the distance used for the rest of this list
          if (v_r == top_u_r) begin
            du_nxt = cand_r;
          end
        end
        st_nxt = S_RE;
      end
      S_OREQ: begin
        st_nxt = S_OLD;
      end
      S_OLD: begin
        o_idx_nxt     = VW'(ov_r);
        o_reach_nxt   = dist_vld_r[ov_r[IDX_W-1:0]];
        o_dist_nxt    = dist_vld_r[ov_r[IDX_W-1:0]] ? $signed(dist_q[DW+VW-1:VW]) : '0;
        o_hasp_nxt    = pred_vld_r[ov_r[IDX_W-1:0]];
        o_pred_nxt    = pred_vld_r[ov_r[IDX_W-1:0]] ? dist_q[VW-1:0] : '0;
        o_last_nxt    = (ov_r + CW'(1)) == n_w;
        out_valid_nxt = 1'b1;
        st_nxt        = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            // graph done: drop degrees and visit marks
            deg_vld_nxt = '0;
            visited_nxt = '0;
            fwd_v_nxt   = 1'b0;
            st_nxt      = S_LOAD;
          end else begin
            ov_nxt = ov_r + CW'(1);
            st_nxt = S_OREQ;
          end
        end
      end
      default: begin
        st_nxt = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      vcount_r    <= MAX_CNT;
      src_r       <= VW'(1);
      s1_v_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      deg_vld_r   <= '0;
      visited_r   <= '0;
      dist_vld_r  <= '0;
      pred_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      s1_v_r      <= in_fire;
      fwd_v_r     <= fwd_v_nxt;
      deg_vld_r   <= deg_vld_nxt;
      visited_r   <= visited_nxt;
      dist_vld_r  <= dist_vld_nxt;
      pred_vld_r  <= pred_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          dsp_pkg::REG_VERTEX_COUNT:  vcount_r <= cfg_ch.data[CW-1:0];
          dsp_pkg::REG_SOURCE_VERTEX: src_r    <= cfg_ch.data[VW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pres_r <= in_ch.edge_present;
      s1_from_r <= in_ch.edge_from;
      s1_to_r   <= in_ch.edge_to;
      s1_w_r    <= WEIGHT_BITS'($unsigned(in_ch.edge_weight));
      s1_last_r <= in_ch.last_edge;
    end
    fwd_idx_r <= s1_from_r;
    fwd_val_r <= deg_wdata;
    root_r    <= root_nxt;
    sp_r      <= sp_nxt;
    top_u_r   <= top_u_nxt;
    top_i_r   <= top_i_nxt;
    top_deg_r <= top_deg_nxt;
    done_r    <= done_nxt;
    k_r       <= k_nxt;
    du_r      <= du_nxt;
    v_r       <= v_nxt;
    cand_r    <= cand_nxt;
    ov_r      <= ov_nxt;
    o_idx_r   <= o_idx_nxt;
    o_reach_r <= o_reach_nxt;
    o_dist_r  <= o_dist_nxt;
    o_hasp_r  <= o_hasp_nxt;
    o_pred_r  <= o_pred_nxt;
    o_last_r  <= o_last_nxt;
  end

  // adjacency lists, tail-major, with the slots under each tail vertex
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q <= adj_mem[adj_raddr];
  end

  // out-degree, read data masked by its valid bit
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q     <= deg_mem[deg_raddr];
    deg_hit_q <= deg_vld_r[deg_raddr];
  end

  // search stack below the top entry
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= {top_u_r, top_i_r};
    end
    stk_q <= stk_mem[stk_addr];
  end

  // finish order
  always_ff @(posedge clk) begin
    if (topo_we) begin
      topo_mem[topo_waddr] <= top_u_r;
    end
    topo_q <= topo_mem[topo_raddr];
  end

  // distance and predecessor
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_q <= dist_mem[dist_raddr];
  end

endmodule

[hw/rtl/dsp_sat_add.sv]
// ----------------------------------------------------------------------------
// dsp_sat_add
// distance plus edge weight, saturated to the signed 32-bit range
// ----------------------------------------------------------------------------
module dsp_sat_add (
  input  logic signed [dsp_pkg::DIST_W-1:0] dist_i,
  input  logic signed [dsp_pkg::DIST_W-1:0] weight_i,
  output logic signed [dsp_pkg::DIST_W-1:0] sum_o
);

  logic signed [dsp_pkg::DIST_W:0] wide;

  assign wide = {dist_i[dsp_pkg::DIST_W-1], dist_i} + {weight_i[dsp_pkg::DIST_W-1], weight_i};

  always_comb begin
    if (wide[dsp_pkg::DIST_W] != wide[dsp_pkg::DIST_W-1]) begin
      // overflow: clamp toward the sign of the true sum
      sum_o = wide[dsp_pkg::DIST_W] ? {1'b1, {(dsp_pkg::DIST_W-1){1'b0}}}
                                     : {1'b0, {(dsp_pkg::DIST_W-1){1'b1}}};
    end else begin
      sum_o = wide[dsp_pkg::DIST_W-1:0];
    end
  end

endmodule

[hw/rtl/dsp_checker.sv]
// ----------------------------------------------------------------------------
// dsp_checker
// port-level checks on the result channel of the shortest path block, and on in_ready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         reachable,
  input logic                         has_predecessor,
  input logic [dsp_pkg::VTX_W-1:0]    predecessor,
  input logic [dsp_pkg::DIST_W-1:0]   distance,
  input logic                         last_vertex
);

  // no edge beats while results are out
  `DSP_ASSERT_IMP(a_busy_out, out_valid, !in_ready)
  // a predecessor means a path
  `DSP_ASSERT_IMP(a_pred_reach, out_valid && has_predecessor, reachable)
  // unreachable reads as zero
  `DSP_ASSERT_IMP(a_unreach_zero, out_valid && !reachable, distance == '0 && !has_predecessor)
  `DSP_ASSERT_IMP(a_nopred_zero, out_valid && !has_predecessor, predecessor == '0)
  // after the final result the block returns to loading
  `DSP_ASSERT_NXT(a_last_done, out_valid && out_ready && last_vertex, !out_valid)

endmodule

bind dag_single_source_shortest_paths dsp_checker u_dsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .reachable       (out_ch.reachable),
  .has_predecessor (out_ch.has_predecessor),
  .predecessor     (out_ch.predecessor),
  .distance        (out_ch.distance),
  .last_vertex     (out_ch.last_vertex)
);

[verif/tb_dag_single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// tb_dag_single_source_shortest_paths
// loads directed and random weighted graphs edge by edge, predicts the distance, reach and
// predecessor of every vertex, and compares each result beat in order
// ----------------------------------------------------------------------------
module tb_dag_single_source_shortest_paths;

  localparam int NV = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic        present;
    logic [5:0]  from;
    logic [5:0]  to;
    logic [15:0] weight;
    logic        last;
  } edge_beat_t;

  typedef struct packed {
    logic [5:0]         vtx;
    logic               reach;
    logic signed [31:0] dist_v;
    logic               has_pred;
    logic [5:0]         pred;
    logic               last;
  } vertex_result_t;

  logic clk;
  logic rst_n;

  dsp_edge_if   in_ch ();
  dsp_result_if out_ch ();
  dsp_cfg_if    cfg_ch ();

  dag_single_source_shortest_paths i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of the graph and registers
  logic [5:0]  adj_to  [NV][NV];
  int          adj_w   [NV][NV];
  int          degree  [NV];
  int          color   [NV];
  logic [6:0]  n_reg;
  logic [5:0]  src_reg;

  edge_beat_t     pending_edges[$];
  vertex_result_t expected_vertices[$];

  int  errors;
  int  cycles;
  bit  quiet;       // no idling in the final part
  int  hold_cycles; // long receiver hold-off
  int  in_gap;
  int  out_gap;
  logic in_taken;   // input beat accepted at the last rising edge

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // walk of one graph: dfs order, then relaxation in topological order
  task automatic compute_distances();
    int n;
    int order[$];
    int sv[NV];
    int se[NV];
    int sp;
    int u;
    int v;
    int i;
    longint d[NV];
    bit dv[NV];
    int p[NV];
    bit pv[NV];
    longint c;
    vertex_result_t r;
    n = (n_reg < 1) ? 1 : ((n_reg > NV) ? NV : int'(n_reg));
    for (int root = 0; root < n; root++) begin
      if (color[root] != 0) continue;
      color[root] = 1;
      sv[0] = root;
      se[0] = 0;
      sp = 1;
      while (sp > 0) begin
        u = sv[sp-1];
        i = se[sp-1];
        if (i < degree[u]) begin
          v = adj_to[u][i];
          se[sp-1] = i + 1;
          if (v < n && color[v] == 0 && sp < NV) begin
            color[v] = 1;
            sv[sp] = v;
            se[sp] = 0;
            sp++;
          end
        end else begin
          color[u] = 2;
          order.push_back(u);
          sp--;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      dv[k] = 0; d[k] = 0; pv[k] = 0; p[k] = 0;
    end
    if (src_reg < n) dv[src_reg] = 1;
    for (int k = order.size(); k > 0; k--) begin
      u = order[k-1];
      if (u >= n || !dv[u]) continue;
      for (int j = 0; j < degree[u]; j++) begin
        v = adj_to[u][j];
        if (v >= n) continue;
        c = d[u] + longint'(adj_w[u][j]);
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        if (!dv[v] || c < d[v]) begin
          dv[v] = 1; d[v] = c; pv[v] = 1; p[v] = u;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r.vtx = k[5:0];
      r.reach = dv[k];
      r.dist_v = dv[k] ? 32'(d[k]) : '0;
      r.has_pred = pv[k];
      r.pred = pv[k] ? p[k][5:0] : '0;
      r.last = (k == n - 1);
      expected_vertices.push_back(r);
    end
    for (int k = 0; k < NV; k++) begin
      degree[k] = 0; color[k] = 0;
    end
  endtask

  // the predictor runs when a beat is accepted
  task automatic absorb_edge(input edge_beat_t b);
    int n;
    n = (n_reg < 1) ? 1 : ((n_reg > NV) ? NV : int'(n_reg));
    if (b.present && b.from < n && b.to < n && degree[b.from] < NV) begin
      adj_to[b.from][degree[b.from]] = b.to;
      adj_w[b.from][degree[b.from]] = int'($signed(b.weight));
      degree[b.from]++;
    end
    if (b.last) compute_distances();
  endtask

  // acceptance seen at the rising edge, used by the driver at the falling edge
  always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        absorb_edge({in_ch.edge_present, in_ch.edge_from, in_ch.edge_to,
                     in_ch.edge_weight, in_ch.last_edge});
        void'(pending_edges.pop_front());
      end
      if (in_ch.valid && !in_taken) begin
        // beat still waiting: hold it on the bus
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else if (pending_edges.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.edge_present, in_ch.edge_from, in_ch.edge_to,
         in_ch.edge_weight, in_ch.last_edge} <= pending_edges[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        report("unexpected result beat", out_ch.vertex_index, -1);
      end else begin
        w = expected_vertices.pop_front();
        if (out_ch.vertex_index !== w.vtx) report("vertex_index", out_ch.vertex_index, w.vtx);
        if (out_ch.reachable !== w.reach) report("reachable", out_ch.reachable, w.reach);
        if (out_ch.distance !== w.dist_v) report("distance", out_ch.distance, w.dist_v);
        if (out_ch.has_predecessor !== w.has_pred)
          report("has_predecessor", out_ch.has_predecessor, w.has_pred);
        if (out_ch.predecessor !== w.pred) report("predecessor", out_ch.predecessor, w.pred);
        if (out_ch.last_vertex !== w.last) report("last_vertex", out_ch.last_vertex, w.last);
      end
    end
  end

  task automatic write_reg(input dsp_pkg::cfg_reg_t idx, input logic [6:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == dsp_pkg::REG_VERTEX_COUNT) n_reg = val;
    else src_reg = val[5:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every result of the graphs so far, plus walk latency slack
  task automatic drain();
    while (pending_edges.size() > 0 || in_ch.valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic push_edge(input bit pr, input int f, input int t, input int wt, input bit l);
    edge_beat_t b;
    b.present = pr; b.from = f[5:0]; b.to = t[5:0]; b.weight = wt[15:0]; b.last = l;
    pending_edges.push_back(b);
  endtask

  // random graph: mostly forward edges over the active range, some noise
  task automatic random_graph(input int n, input int edges);
    int f;
    int t;
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        f = $urandom_range(0, 63);
        t = $urandom_range(0, 63);
      end else begin
        f = $urandom_range(0, (n > 1) ? n - 2 : 0);
        t = $urandom_range(f, n - 1);
        if ($urandom_range(0, 7) != 0 && t == f && n > 1) t = f + 1;
      end
      push_edge($urandom_range(0, 15) != 0, f, t,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 400) - 200,
                e == edges - 1);
    end
  endtask

  initial begin
    int n;
    errors = 0; cycles = 0; quiet = 0; hold_cycles = 0; in_gap = 0; out_gap = 0;
    n_reg = 7'd64; src_reg = 6'd1;
    for (int k = 0; k < NV; k++) begin
      degree[k] = 0; color[k] = 0;
    end
    in_ch.valid = 0; in_ch.edge_present = 0; in_ch.edge_from = 0; in_ch.edge_to = 0;
    in_ch.edge_weight = 0; in_ch.last_edge = 0;
    cfg_ch.valid = 0; cfg_ch.index = dsp_pkg::REG_VERTEX_COUNT; cfg_ch.data = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: reset settings, extremes, cycle, self-loop, bare end, count clamping
    push_edge(1, 1, 2, 16'h7fff, 0);
    push_edge(1, 2, 3, 16'h8000, 0);
    push_edge(1, 3, 3, 16'hffff, 0);
    push_edge(1, 63, 0, 5, 0);
    push_edge(1, 0, 63, 16'h5555, 0);
    push_edge(1, 4, 1, 1, 0);
    push_edge(1, 1, 4, 2, 0);
    push_edge(0, 1, 5, 7, 1);
    drain();
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd1);
    write_reg(dsp_pkg::REG_SOURCE_VERTEX, 7'd0);
    push_edge(1, 0, 0, -3, 0);
    push_edge(1, 0, 1, 4, 1);
    drain();
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd0);
    push_edge(0, 0, 0, 0, 1);
    drain();
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd100);
    write_reg(dsp_pkg::REG_SOURCE_VERTEX, 7'd63);
    push_edge(1, 63, 10, 16'haaaa, 0);
    // full list on one tail, the extra edges dropped
    for (int e = 0; e < 66; e++) push_edge(1, 10, e % 64, e, 0);
    push_edge(1, 10, 11, 1, 1);
    drain();
    // shrinking count after loading: stored edges past n skipped
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd20);
    write_reg(dsp_pkg::REG_SOURCE_VERTEX, 7'd0);
    push_edge(1, 0, 15, 3, 0);
    push_edge(1, 0, 19, 3, 0);
    drain();
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd16);
    write_reg(dsp_pkg::REG_SOURCE_VERTEX, 7'd30);
    push_edge(1, 15, 1, 1, 1);
    drain();

    // long receiver hold-off while graphs keep coming
    write_reg(dsp_pkg::REG_VERTEX_COUNT, 7'd8);
    write_reg(dsp_pkg::REG_SOURCE_VERTEX, 7'd0);
    hold_cycles = 400;
    for (int g = 0; g < 3; g++) random_graph(8, 6);
    drain();

    // random part
    for (int g = 0; g < 30; g++) begin
      if (g == 24) quiet = 1;
      n = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 127))
                                      : int'($urandom_range(1, 16));
      write_reg(dsp_pkg::REG_VERTEX_COUNT, n[6:0]);
      write_reg(dsp_pkg::REG_SOURCE_VERTEX,
                7'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                   : $urandom_range(0, (n > 16 || n < 1) ? 3 : n - 1)));
      n = (n < 1) ? 1 : ((n > 64) ? 64 : n);
      random_graph(n, $urandom_range(1, 20));
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[dag_single_source_shortest_paths.f]
+incdir+hw/rtl
hw/rtl/dsp_pkg.sv
hw/rtl/dsp_ifs.sv
hw/rtl/dsp_sat_add.sv
hw/rtl/dag_single_source_shortest_paths.sv
hw/rtl/dsp_checker.sv
verif/tb_dag_single_source_shortest_paths.sv
